[rtl/core/assert_macros.svh]
// Assertion macros shared by the segment generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define DSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/dsg_pkg.sv]
// ----------------------------------------------------------------------------
// dsg_pkg
// Types, constants and the segment order function of the segment generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsg_pkg;

  // Grid and field widths.
  localparam int GRID_SIZE = 16;
  localparam int COORD_W   = 4;
  localparam int ODD_BIAS  = 32;
  // Base-case coordinates (signed, mirrored x may be negative).
  localparam int BC_W      = 6;
  // Coordinate sums and their biased form.
  localparam int SUM_W     = 7;
  localparam int BIAS_W    = 8;
  // Step counts and ranks.
  localparam int CNT_W     = 5;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
    logic rank_clr;
    logic rank_en;
    logic step;
  } dsg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic u_last;
    logic out_valid;
  } dsg_status_t;

  // Odd sums are pushed up by the bias before ordering.
  function automatic logic signed [BIAS_W-1:0] biased(input logic signed [SUM_W-1:0] n);
    logic signed [BIAS_W-1:0] ext;
    begin
      ext = BIAS_W'(n);
      biased = n[0] ? ext + BIAS_W'(ODD_BIAS) : ext;
    end
  endfunction

  // a precedes b when, at the lowest bit where the biased values differ,
  // a holds a one.
  function automatic logic precedes(input logic signed [SUM_W-1:0] a,
                                    input logic signed [SUM_W-1:0] b);
    logic [BIAS_W-1:0] ba;
    logic [BIAS_W-1:0] diff;
    logic [BIAS_W-1:0] low;
    begin
      ba       = biased(a);
      diff     = ba ^ biased(b);
      low      = diff & (~diff + BIAS_W'(1));
      precedes = (diff != '0) && ((ba & low) != '0);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/digital_segment_generator_unit.sv]
// ----------------------------------------------------------------------------
// digital_segment_generator_unit
// Consistent digital line segment generator, one grid point per output beat.
// ----------------------------------------------------------------------------
// Takes one pair of points at a time and returns the 1 + |dx| + |dy| points of
// the segment from start to end, the final one flagged by last_point. With
// L = |dx| + |dy| steps, every step ranks its coordinate sum against all L
// sums of the interval, one sum per cycle in the rank scan, then moves the
// point. A new pair is taken only once the previous segment's final point
// sits in the output register.
`default_nettype none

module digital_segment_generator_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  dsg_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output dsg_pkg::out_item_t  out_item
);
  import dsg_pkg::*;

  dsg_cmd_t    cmd;
  dsg_status_t status;

  // Sequencer.
  dsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Point walk and output register.
  dsg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

  assign out_valid = status.out_valid;

endmodule

`default_nettype wire

[rtl/core/dsg_ctrl.sv]
// ----------------------------------------------------------------------------
// dsg_ctrl
// Controller: sequences load, point emission, rank scan and coordinate step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsg_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  out_stall,
  input  dsg_pkg::dsg_status_t status,
  output dsg_pkg::dsg_cmd_t    cmd
);
  import dsg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;
  localparam logic [1:0] ST_STEP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !status.out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit     = 1'b1;
          cmd.rank_clr = 1'b1;
          state_next   = status.cnt_zero ? ST_IDLE : ST_RANK;
        end
      end
      ST_RANK: begin
        cmd.rank_en = 1'b1;
        if (status.u_last) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_EMIT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DSG_ASSERT(a_emit_free, cmd.emit |-> out_free, "point emitted into a full output register")
  `DSG_ASSERT(a_rank_hold, (state == ST_RANK && !status.u_last) |=> (state == ST_RANK), "rank scan left early")

endmodule

`default_nettype wire

[rtl/core/dsg_datapath.sv]
// ----------------------------------------------------------------------------
// dsg_datapath
// Datapath: quadrant reduction, rank accumulation, point walk, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsg_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  dsg_pkg::in_item_t    in_item,
  input  wire                  out_stall,
  input  dsg_pkg::dsg_cmd_t    cmd,
  output dsg_pkg::dsg_status_t status,
  output dsg_pkg::out_item_t   out_item
);
  import dsg_pkg::*;

  logic [COORD_W-1:0]       x1, y1, x2, y2;
  logic signed [BC_W-1:0]   bx1, by1, bx2, by2;
  logic                     ld_mirror, ld_rev;
  logic signed [SUM_W-1:0]  ld_s1, ld_s2, ld_len;

  logic signed [BC_W-1:0]   bx, by;
  logic signed [SUM_W-1:0]  s1, s2, s, u;
  logic [CNT_W-1:0]         dx, rank, cnt;
  logic                     mirror, rev;
  logic                     out_valid;
  logic                     step_x;
  logic signed [BC_W-1:0]   out_x;

  // Clamp coordinates to the grid.
  assign x1 = (in_item.start_x > COORD_MAX) ? COORD_MAX : in_item.start_x;
  assign y1 = (in_item.start_y > COORD_MAX) ? COORD_MAX : in_item.start_y;
  assign x2 = (in_item.end_x   > COORD_MAX) ? COORD_MAX : in_item.end_x;
  assign y2 = (in_item.end_y   > COORD_MAX) ? COORD_MAX : in_item.end_y;

  // Reduce the quadrant to the base case where neither coordinate falls.
  always_comb begin
    ld_mirror = 1'b0;
    ld_rev    = 1'b0;
    bx1 = BC_W'(x1);
    by1 = BC_W'(y1);
    bx2 = BC_W'(x2);
    by2 = BC_W'(y2);
    if (x1 >= x2 && y1 >= y2) begin
      bx1 = BC_W'(x2);
      by1 = BC_W'(y2);
      bx2 = BC_W'(x1);
      by2 = BC_W'(y1);
      ld_rev = 1'b1;
    end else if (x2 < x1 && y2 > y1) begin
      bx1 = -BC_W'(x1);
      bx2 = -BC_W'(x2);
      ld_mirror = 1'b1;
    end else if (x1 < x2 && y2 < y1) begin
      bx1 = -BC_W'(x2);
      by1 = BC_W'(y2);
      bx2 = -BC_W'(x1);
      by2 = BC_W'(y1);
      ld_mirror = 1'b1;
      ld_rev    = 1'b1;
    end
    ld_s1  = SUM_W'(bx1) + SUM_W'(by1);
    ld_s2  = SUM_W'(bx2) + SUM_W'(by2);
    ld_len = ld_s2 - ld_s1;
  end

  assign step_x = (rank < dx);
  assign out_x  = mirror ? -bx : bx;

  // Walk state: segment parameters, current point, sum under test, scan index and rank.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mirror <= ld_mirror;
      rev    <= ld_rev;
      s1     <= ld_s1;
      s2     <= ld_s2;
      dx     <= CNT_W'(bx2 - bx1);
      cnt    <= ld_len[CNT_W-1:0];
      bx     <= ld_rev ? bx2 : bx1;
      by     <= ld_rev ? by2 : by1;
      s      <= ld_rev ? ld_s2 - SUM_W'(1) : ld_s1;
    end
    if (cmd.rank_clr) begin
      rank <= '0;
      u    <= s1;
    end
    if (cmd.rank_en) begin
      if (u != s && precedes(u, s)) begin
        rank <= rank + CNT_W'(1);
      end
      u <= u + SUM_W'(1);
    end
    if (cmd.step) begin
      cnt <= cnt - CNT_W'(1);
      if (rev) begin
        bx <= step_x ? bx - BC_W'(1) : bx;
        by <= step_x ? by : by - BC_W'(1);
        s  <= s - SUM_W'(1);
      end else begin
        bx <= step_x ? bx + BC_W'(1) : bx;
        by <= step_x ? by : by + BC_W'(1);
        s  <= s + SUM_W'(1);
      end
    end
  end

  // Output register: one beat held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.point_x    <= out_x[COORD_W-1:0];
      out_item.point_y    <= by[COORD_W-1:0];
      out_item.last_point <= (cnt == '0);
    end
  end

  assign status.cnt_zero  = (cnt == '0);
  assign status.u_last    = ((u + SUM_W'(1)) == s2);
  assign status.out_valid = out_valid;

  `DSG_ASSERT(a_emit_valid, cmd.emit |=> out_valid, "emitted point not presented")

endmodule

`default_nettype wire

[tb/segment_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_checker
// Watches both channels of the segment generator, predicts the point stream
// of every accepted pair of endpoints, and compares each output beat with it.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  dsg_pkg::in_item_t   in_item,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  dsg_pkg::out_item_t  out_item,
  output int                  fail_count,
  output int                  points_pending
);
  import dsg_pkg::*;

  out_item_t point_queue[$];

  // Number of trailing zeros; zero itself counts as infinitely divisible.
  function automatic int twos_depth(input int n);
    int c;
    c = 0;
    if (n == 0) return 64;
    while (n[0] == 1'b0) begin
      n = n >>> 1;
      c++;
    end
    return c;
  endfunction

  // Odd sums are pushed up by the bias, then compared by how long each
  // stays divisible while both are stepped down together.
  function automatic bit sum_before(input int a, input int b);
    int ba, bb, da, db;
    ba = a[0] ? a + ODD_BIAS : a;
    bb = b[0] ? b + ODD_BIAS : b;
    for (int t = 0; t < 1024; t++) begin
      da = twos_depth(ba - t);
      db = twos_depth(bb - t);
      if (da < db) return 1'b1;
      if (da > db) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Walks the base case, where neither coordinate decreases.
  task automatic walk_base(input int x1, input int y1, input int x2, input int y2,
                           ref int xs[$], ref int ys[$]);
    int s1, s2, dx, cx, cy, rank;
    s1 = x1 + y1;
    s2 = x2 + y2;
    dx = x2 - x1;
    cx = x1;
    cy = y1;
    xs = {xs, cx};
    ys = {ys, cy};
    for (int s = s1; s < s2; s++) begin
      rank = 0;
      for (int u = s1; u < s2; u++)
        if (u != s && sum_before(u, s)) rank++;
      if (rank < dx) cx++;
      else cy++;
      xs = {xs, cx};
      ys = {ys, cy};
    end
  endtask

  // Reduces the pair to the base case and queues the expected points.
  task automatic predict_segment(input in_item_t pair);
    int x1, y1, x2, y2, n, src;
    int xs[$], ys[$];
    bit flip, mirror;
    out_item_t pt;
    x1 = pair.start_x;
    y1 = pair.start_y;
    x2 = pair.end_x;
    y2 = pair.end_y;
    flip = 1'b0;
    mirror = 1'b0;
    if (x1 == x2 && y1 == y2) begin
      xs = {xs, x1};
      ys = {ys, y1};
    end else if (x1 >= x2 && y1 >= y2) begin
      walk_base(x2, y2, x1, y1, xs, ys);
      flip = 1'b1;
    end else if (x2 < x1 && y2 > y1) begin
      walk_base(-x1, y1, -x2, y2, xs, ys);
      mirror = 1'b1;
    end else if (x1 < x2 && y2 < y1) begin
      walk_base(-x2, y2, -x1, y1, xs, ys);
      mirror = 1'b1;
      flip = 1'b1;
    end else begin
      walk_base(x1, y1, x2, y2, xs, ys);
    end
    n = xs.size();
    for (int k = 0; k < n; k++) begin
      src = flip ? n - 1 - k : k;
      pt.point_x = COORD_W'(mirror ? -xs[src] : xs[src]);
      pt.point_y = COORD_W'(ys[src]);
      pt.last_point = (k == n - 1);
      point_queue = {point_queue, pt};
    end
  endtask

  assign points_pending = point_queue.size();

  // Sample both channels at each edge, before the block's outputs move.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) predict_segment(in_item);
      if (out_valid && !out_stall) begin
        if (point_queue.size() == 0) begin
          $display("%0t: unexpected point beat, actual %h", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = point_queue.pop_front();
          if (want.point_x !== out_item.point_x || want.point_y !== out_item.point_y ||
              want.last_point !== out_item.last_point) begin
            $display("%0t: point mismatch, expected x=%0d y=%0d last=%0d, %s",
                     $time, want.point_x, want.point_y, want.last_point, "actual");
            $display("%0t:   actual x=%0d y=%0d last=%0d",
                     $time, out_item.point_x, out_item.point_y, out_item.last_point);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives endpoint pairs into the segment generator with random idling and a
// long output hold-off, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import dsg_pkg::*;

  localparam int RANDOM_PAIRS = 350;
  localparam int STALL_LIMIT  = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        points_pending;
  int        cycle_count = 0;
  int        quiet_cycles = 0;
  int        pairs_sent = 0;

  always #6 clk = ~clk;

  digital_segment_generator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  segment_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .points_pending(points_pending)
  );

  // Receiver: random stalls, one long hold-off, then a stretch with none.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= 3000 && cycle_count < 3600) out_stall <= 1'b1;
    else if (cycle_count >= 8000 && cycle_count < 14000) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 24);
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one pair and holds it until it is taken.
  task automatic send_pair(input logic [3:0] sx, input logic [3:0] sy,
                           input logic [3:0] ex, input logic [3:0] ey);
    int gap;
    gap = 0;
    if (!(pairs_sent >= 100 && pairs_sent < 180))
      while ($urandom_range(99) < 24) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= '{start_x: sx, start_y: sy, end_x: ex, end_y: ey};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    pairs_sent++;
  endtask

  initial begin
    logic [15:0] r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Directed: equal points, corners, every quadrant, pure axes.
    send_pair(4'd0, 4'd0, 4'd0, 4'd0);
    send_pair(4'd15, 4'd15, 4'd15, 4'd15);
    send_pair(4'd7, 4'd9, 4'd7, 4'd9);
    send_pair(4'd0, 4'd0, 4'd15, 4'd15);
    send_pair(4'd15, 4'd15, 4'd0, 4'd0);
    send_pair(4'd15, 4'd0, 4'd0, 4'd15);
    send_pair(4'd0, 4'd15, 4'd15, 4'd0);
    send_pair(4'd2, 4'd3, 4'd9, 4'd5);
    send_pair(4'd9, 4'd5, 4'd2, 4'd3);
    send_pair(4'd10, 4'd1, 4'd4, 4'd8);
    send_pair(4'd4, 4'd8, 4'd10, 4'd1);
    send_pair(4'd3, 4'd4, 4'd12, 4'd4);
    send_pair(4'd12, 4'd4, 4'd3, 4'd4);
    send_pair(4'd6, 4'd1, 4'd6, 4'd14);
    send_pair(4'd6, 4'd14, 4'd6, 4'd1);
    send_pair(4'd0, 4'd15, 4'd15, 4'd15);
    send_pair(4'd1, 4'd1, 4'd2, 4'd2);
    send_pair(4'd5, 4'd5, 4'd4, 4'd6);
    // Random: mostly short segments, some with freely random endpoints.
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      r = 16'($urandom);
      if ($urandom_range(3) == 0) begin
        send_pair(r[15:12], r[11:8], r[7:4], r[3:0]);
      end else begin
        send_pair(r[15:12], r[11:8],
                  4'(int'(r[15:12]) + $urandom_range(6) - 3),
                  4'(int'(r[11:8]) + $urandom_range(6) - 3));
      end
    end
    in_valid <= 1'b0;
    // Let the checker queue the last pair before watching the drain.
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
